// File: rtl/rcu_pkg.sv
// rcu_pkg: shared types, widths and codes of the radix converter unit
// no dependencies; imported by every rcu module and by radix_converter_unit
package rcu_pkg;

	// fixed field widths
	localparam int CHAR_W     = 8;
	localparam int OUT_CHAR_W = 7;
	localparam int STATUS_W   = 2;
	localparam int BASE_W     = 6;
	localparam int DIGIT_W    = 6;

	// digit store geometry
	localparam int STORE_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

	// parameter defaults
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 32;

	// configuration port
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_BASE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET_BASE = 1'd1;
	localparam logic [BASE_W-1:0]     BASE_RESET      = 6'd10;

	// status codes
	localparam logic [STATUS_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ERR_DIGIT    = 2'd1;
	localparam logic [STATUS_W-1:0] ERR_OVERFLOW = 2'd2;

	// control of the character accumulate unit
	typedef struct packed {
		logic accept;  // item taken, start multiply
		logic update;  // fold product and digit into the accumulator
		logic clear;   // number done, back to zero
	} mac_ctl_t;

endpackage

// File: rtl/radix_converter_unit.sv
// radix_converter_unit: top level, digit string in source base to digits in target base
// depends on rcu_pkg, rcu_char_mac, rcu_divider, rcu_digit_store
//
//   channel   | direction | payload
//   s_axis    | in        | tdata = digit_char[7:0], tlast = last_digit
//   m_axis    | out       | tdata = out_char[6:0] + one zero bit, tuser = status, tlast = last_out
//   cfg       | in        | cfg_addr 0 source_base, 1 target_base, cfg_wdata[5:0]
//
// a character that is not final goes through accept, then multiply-add
// a final character goes through accept, multiply-add and check, then one bit-serial division
// per output digit, then a store read and a load per emitted digit
// the output register lets the next number start while the last item waits on m_axis_tready
// reset returns both bases to 10 and clears accumulator, error and digit count
module radix_converter_unit #(
	parameter int VALUE_BITS = rcu_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = rcu_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// digit_char[7:0]
	input  logic [7:0]                    s_axis_tdata,
	input  logic                          s_axis_tlast,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// out_char[6:0], zero [7]
	output logic [7:0]                    m_axis_tdata,
	// status[1:0]
	output logic [rcu_pkg::STATUS_W-1:0]  m_axis_tuser,
	output logic                          m_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic                          cfg_we,
	input  logic [rcu_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rcu_pkg::BASE_W-1:0]    cfg_wdata
);
	import rcu_pkg::*;

	localparam int DIGIT_LIMIT = (MAX_DIGITS < STORE_DEPTH) ? MAX_DIGITS : STORE_DEPTH;
	localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(DIGIT_LIMIT);

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

	localparam logic [OUT_CHAR_W-1:0] SYM_0 = 7'h30;
	localparam logic [OUT_CHAR_W-1:0] SYM_A = 7'h41;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_ERROR = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_LOAD  = 3'd6;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) r = BASE_MIN;
		if (b > BASE_MAX) r = BASE_MAX;
		return r;
	endfunction

	function automatic logic [OUT_CHAR_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
		logic [OUT_CHAR_W-1:0] r;
		if (d < DIGIT_W'(10)) r = SYM_0 + OUT_CHAR_W'(d);
		else r = SYM_A + OUT_CHAR_W'(d - DIGIT_W'(10));
		return r;
	endfunction

	logic [BASE_W-1:0] src_base_q;
	logic [BASE_W-1:0] tgt_base_q;
	logic [BASE_W-1:0] src_base;
	logic [BASE_W-1:0] tgt_base;

	logic [2:0]          state_q;
	logic                last_s1;
	logic [COUNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic [STATUS_W-1:0] res_status_q;

	logic                  out_valid_q;
	logic [OUT_CHAR_W-1:0] out_char_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_last_q;

	mac_ctl_t              mac_ctl;
	logic [VALUE_BITS-1:0] acc;
	logic [STATUS_W-1:0]   err;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DIGIT_W-1:0]    div_rem;

	logic               st_we;
	logic               st_re;
	logic [DIGIT_W-1:0] st_rdata;

	logic in_accept;
	logic slot_free;
	logic digit_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= BASE_RESET;
			tgt_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SOURCE_BASE: src_base_q <= cfg_wdata;
				REG_TARGET_BASE: tgt_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign src_base = clamp_base(src_base_q);
	assign tgt_base = clamp_base(tgt_base_q);

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign digit_full    = (cnt_q >= LIMIT);

	// unit control
	always_comb begin
		mac_ctl.accept = in_accept;
		mac_ctl.update = (state_q == ST_MAC);
		mac_ctl.clear  = (state_q == ST_CHECK);
		div_start      = ((state_q == ST_CHECK) && (err == ERR_NONE)) ||
		                 ((state_q == ST_DIV) && div_done && !digit_full && (div_quo != '0));
		div_dividend   = (state_q == ST_CHECK) ? acc : div_quo;
		st_we          = (state_q == ST_DIV) && div_done && !digit_full;
		st_re          = (state_q == ST_READ);
	end

	rcu_char_mac #(
		.VALUE_BITS(VALUE_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.digit_char (s_axis_tdata),
		.source_base(src_base),
		.acc        (acc),
		.err        (err)
	);

	rcu_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (tgt_base),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	rcu_digit_store u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(div_rem),
		.re   (st_re),
		.raddr(rd_idx_q),
		.rdata(st_rdata)
	);

	// final flag of the item in flight
	always_ff @(posedge clk) begin
		if (in_accept) begin
			last_s1 <= s_axis_tlast;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			res_status_q <= ERR_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_MAC;
				end
				ST_MAC: begin
					state_q <= last_s1 ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					cnt_q        <= '0;
					res_status_q <= err;
					state_q      <= (err == ERR_NONE) ? ST_DIV : ST_ERROR;
				end
				ST_DIV: begin
					if (div_done) begin
						if (digit_full) begin
							res_status_q <= ERR_OVERFLOW;
							state_q      <= ST_ERROR;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if (div_quo == '0) begin
								rd_idx_q <= cnt_q[ADDR_W-1:0];
								state_q  <= ST_READ;
							end
						end
					end
				end
				ST_ERROR: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (slot_free) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free && ((state_q == ST_ERROR) || (state_q == ST_LOAD))) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && (state_q == ST_ERROR)) begin
			out_char_q   <= '0;
			out_status_q <= res_status_q;
			out_last_q   <= 1'b1;
		end else if (slot_free && (state_q == ST_LOAD)) begin
			out_char_q   <= digit_symbol(st_rdata);
			out_status_q <= ERR_NONE;
			out_last_q   <= (rd_idx_q == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_char_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// digit count never runs past the store limit
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= LIMIT)
		else $error("digit count beyond limit");

	// emission only reads entries written in this conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (COUNT_W'(rd_idx_q) < cnt_q))
		else $error("read of unwritten digit entry");

	// divider results only arrive while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == ST_DIV))
		else $error("stray divider completion");

	// remainder is a valid digit of the target base
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_rem < tgt_base))
		else $error("remainder not below target base");

	// first error of a number sticks until the number is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		((err != ERR_NONE) && !mac_ctl.clear) |=> ($past(err) == err))
		else $error("error code changed inside a number");
`endif

endmodule

// File: rtl/rcu_char_mac.sv
// rcu_char_mac: decodes one digit character and folds it into the accumulator
// two steps per item: registered multiply, then add with range check
// depends on rcu_pkg
module rcu_char_mac #(
	parameter int VALUE_BITS = rcu_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rcu_pkg::mac_ctl_t            ctl,
	input  logic [rcu_pkg::CHAR_W-1:0]   digit_char,
	input  logic [rcu_pkg::BASE_W-1:0]   source_base,
	output logic [VALUE_BITS-1:0]        acc,
	output logic [rcu_pkg::STATUS_W-1:0] err
);
	import rcu_pkg::*;

	localparam int PROD_W = VALUE_BITS + BASE_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] LETTER_0 = 8'd10;

	logic [VALUE_BITS-1:0] acc_q;
	logic [STATUS_W-1:0]   err_q;
	logic [PROD_W-1:0]     prod_s1;
	logic [DIGIT_W-1:0]    dval_s1;
	logic                  bad_s1;

	logic [CHAR_W-1:0]  dec_full;
	logic               dec_ok;
	logic [DIGIT_W-1:0] dec_val;
	logic [SUM_W-1:0]   sum;
	logic               ovf;

	// character to digit value
	always_comb begin
		dec_full = '0;
		dec_ok   = 1'b1;
		if (digit_char inside {[CH_0:CH_9]}) begin
			dec_full = digit_char - CH_0;
		end else if (digit_char inside {[CH_LO_A:CH_LO_Z]}) begin
			dec_full = digit_char - CH_LO_A + LETTER_0;
		end else if (digit_char inside {[CH_UP_A:CH_UP_Z]}) begin
			dec_full = digit_char - CH_UP_A + LETTER_0;
		end else begin
			dec_ok = 1'b0;
		end
		dec_val = dec_full[DIGIT_W-1:0];
	end

	// stage one: product of accumulator and base
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			prod_s1 <= PROD_W'(acc_q) * PROD_W'(source_base);
			dval_s1 <= dec_val;
			bad_s1  <= !dec_ok || (dec_val >= source_base);
		end
	end

	// stage two: add digit, range check against value width
	assign sum = SUM_W'(prod_s1) + SUM_W'(dval_s1);
	assign ovf = |sum[SUM_W-1:VALUE_BITS];

	// accumulator and first error of the number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= ERR_NONE;
		end else if (ctl.clear) begin
			acc_q <= '0;
			err_q <= ERR_NONE;
		end else if (ctl.update && err_q == ERR_NONE) begin
			if (bad_s1) begin
				err_q <= ERR_DIGIT;
			end else if (ovf) begin
				err_q <= ERR_OVERFLOW;
			end else begin
				acc_q <= sum[VALUE_BITS-1:0];
			end
		end
	end

	assign acc = acc_q;
	assign err = err_q;

endmodule

// File: rtl/rcu_divider.sv
// rcu_divider: bit-serial restoring divider, value by a 6-bit base
// one quotient bit per cycle, done pulses after VALUE_BITS steps
// depends on rcu_pkg
module rcu_divider #(
	parameter int VALUE_BITS = rcu_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [VALUE_BITS-1:0]       dividend,
	input  logic [rcu_pkg::BASE_W-1:0]  divisor,
	output logic                        done,
	output logic [VALUE_BITS-1:0]       quotient,
	output logic [rcu_pkg::DIGIT_W-1:0] remainder
);
	import rcu_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;

	logic [DIGIT_W:0]   trial;
	logic               fits;
	logic [DIGIT_W:0]   diff;
	logic [DIGIT_W-1:0] rem_next;

	// one restoring step
	always_comb begin
		trial    = {rem_q, quo_q[VALUE_BITS-1]};
		fits     = trial >= {1'b0, divisor};
		diff     = trial - {1'b0, divisor};
		rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts in over the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/rcu_digit_store.sv
// rcu_digit_store: 32 x 6 digit memory, one write and one read port
// read data is registered
// depends on rcu_pkg
module rcu_digit_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rcu_pkg::ADDR_W-1:0]  waddr,
	input  logic [rcu_pkg::DIGIT_W-1:0] wdata,
	input  logic                        re,
	input  logic [rcu_pkg::ADDR_W-1:0]  raddr,
	output logic [rcu_pkg::DIGIT_W-1:0] rdata
);
	import rcu_pkg::*;

	logic [DIGIT_W-1:0] mem [STORE_DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
